### rtl/core/wctc_pkg.sv
// shared types, constants and helpers for the wall column texel coordinate unit
package wctc_pkg;

    // field widths
    localparam int COORD_W = 16;
    localparam int HIT_W   = 32;
    localparam int DIM_W   = 13;
    localparam int TEXEL_W = 12;
    localparam int IDX_W   = 4;
    localparam int OFF_W   = 16;
    localparam int LEN_W   = 17;
    localparam int SPAN_W  = 18;
    localparam int Q_W     = DIM_W;
    localparam int PROD_Y_W = OFF_W + DIM_W;
    localparam int NUM_TEX = 4;

    // divider steps, one quotient bit each
    localparam int DIV_STEPS = Q_W;

    localparam logic [TEXEL_W-1:0] TEXEL_MAX = {TEXEL_W{1'b1}};

    // texture ids
    localparam logic [1:0] TEX_NORTH = 2'd0;
    localparam logic [1:0] TEX_SOUTH = 2'd1;
    localparam logic [1:0] TEX_WEST  = 2'd2;
    localparam logic [1:0] TEX_EAST  = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_NORTH_WIDTH  = 4'd0;
    localparam logic [IDX_W-1:0] CFG_NORTH_HEIGHT = 4'd1;
    localparam logic [IDX_W-1:0] CFG_SOUTH_WIDTH  = 4'd2;
    localparam logic [IDX_W-1:0] CFG_SOUTH_HEIGHT = 4'd3;
    localparam logic [IDX_W-1:0] CFG_WEST_WIDTH   = 4'd4;
    localparam logic [IDX_W-1:0] CFG_WEST_HEIGHT  = 4'd5;
    localparam logic [IDX_W-1:0] CFG_EAST_WIDTH   = 4'd6;
    localparam logic [IDX_W-1:0] CFG_EAST_HEIGHT  = 4'd7;

    typedef logic [DIM_W-1:0] dim_t;

    // one input pixel
    typedef struct packed {
        logic [COORD_W-1:0] screen_x;
        logic [COORD_W-1:0] screen_y;
        logic [COORD_W-1:0] span_start;
        logic [COORD_W-1:0] span_end;
        logic               wall_side;
        logic [HIT_W-1:0]   hit_x_coord;
        logic [HIT_W-1:0]   hit_y_coord;
        logic               step_x_positive;
        logic               step_y_positive;
    } pix_t;

    // per-item fields that ride along the whole pipe
    typedef struct packed {
        logic               write_pixel;
        logic               fill_red;
        logic [1:0]         texture_id;
        logic               active;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
    } meta_t;

    // after selection and span checks
    typedef struct packed {
        meta_t            meta;
        dim_t             w_m1;
        dim_t             h_m1;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
    } prep_t;

    // divider pipe contents
    typedef struct packed {
        meta_t            meta;
        dim_t             tex_x;
        logic [LEN_W-1:0] rem;
        logic [LEN_W-1:0] len;
        logic [Q_W-1:0]   qd;
    } div_t;

    // clamp a 13-bit texel coordinate to the 12-bit range
    function automatic logic [TEXEL_W-1:0] sat_texel(input dim_t v);
        logic [TEXEL_W-1:0] r;
        r = v[DIM_W-1] ? TEXEL_MAX : v[TEXEL_W-1:0];
        return r;
    endfunction

endpackage

### rtl/core/wctc_cfg_regs.sv
// texture size register file
module wctc_cfg_regs
    import wctc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  dim_t             wr_data,
    output dim_t             width_reg  [NUM_TEX],
    output dim_t             height_reg [NUM_TEX]
);

    // decode the index, ignore anything past the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TEX; i++) begin
                width_reg[i]  <= '0;
                height_reg[i] <= '0;
            end
        end else if (wr_en) begin
            case (wr_index)
                CFG_NORTH_WIDTH:  width_reg[TEX_NORTH]  <= wr_data;
                CFG_NORTH_HEIGHT: height_reg[TEX_NORTH] <= wr_data;
                CFG_SOUTH_WIDTH:  width_reg[TEX_SOUTH]  <= wr_data;
                CFG_SOUTH_HEIGHT: height_reg[TEX_SOUTH] <= wr_data;
                CFG_WEST_WIDTH:   width_reg[TEX_WEST]   <= wr_data;
                CFG_WEST_HEIGHT:  height_reg[TEX_WEST]  <= wr_data;
                CFG_EAST_WIDTH:   width_reg[TEX_EAST]   <= wr_data;
                CFG_EAST_HEIGHT:  height_reg[TEX_EAST]  <= wr_data;
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/wctc_prep.sv
// first stage: texture select, span fixup, screen and span checks
module wctc_prep
    import wctc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768,
    parameter int FRAC_BITS     = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load_en,
    input  logic                 in_valid,
    input  pix_t                 pix,
    input  dim_t                 tex_width  [NUM_TEX],
    input  dim_t                 tex_height [NUM_TEX],
    output logic                 valid_reg,
    output prep_t                stage_reg,
    output logic [FRAC_BITS-1:0] frac_reg
);

    localparam logic [COORD_W-1:0] SCR_W = COORD_W'(SCREEN_WIDTH);
    localparam logic [COORD_W-1:0] SCR_H = COORD_W'(SCREEN_HEIGHT);

    logic [1:0]               id;
    logic [HIT_W-1:0]         hit;
    dim_t                     w;
    dim_t                     h;
    logic                     missing;
    logic signed [SPAN_W-1:0] start_s;
    logic signed [SPAN_W-1:0] end_s;
    logic signed [SPAN_W-1:0] end_eff;
    logic signed [SPAN_W-1:0] y_s;
    logic [SPAN_W-1:0]        off_full;
    logic [SPAN_W-1:0]        len_full;
    logic                     on_screen;
    logic                     in_span;
    prep_t                    stage_next;

    // texture choice from side and step direction
    always_comb begin
        if (pix.wall_side) begin
            id  = pix.step_y_positive ? TEX_SOUTH : TEX_NORTH;
            hit = pix.hit_y_coord;
        end else begin
            id  = pix.step_x_positive ? TEX_EAST : TEX_WEST;
            hit = pix.hit_x_coord;
        end
        w       = tex_width[id];
        h       = tex_height[id];
        missing = (w == '0) || (h == '0);
    end

    // span end fixup and visibility
    always_comb begin
        start_s = {{(SPAN_W-COORD_W){pix.span_start[COORD_W-1]}}, pix.span_start};
        end_s   = {{(SPAN_W-COORD_W){pix.span_end[COORD_W-1]}}, pix.span_end};
        y_s     = {{(SPAN_W-COORD_W){pix.screen_y[COORD_W-1]}}, pix.screen_y};
        if (!missing && (end_s <= start_s)) begin
            end_eff = start_s + SPAN_W'(1);
        end else begin
            end_eff = end_s;
        end
        on_screen = !pix.screen_x[COORD_W-1] && (pix.screen_x < SCR_W) &&
                    !pix.screen_y[COORD_W-1] && (pix.screen_y < SCR_H);
        in_span   = (y_s >= start_s) && (y_s <= end_eff);
        off_full  = y_s - start_s;
        len_full  = end_eff - start_s + SPAN_W'(1);
    end

    always_comb begin
        stage_next.meta.write_pixel = on_screen && in_span;
        stage_next.meta.fill_red    = missing;
        stage_next.meta.texture_id  = id;
        stage_next.meta.active      = on_screen && in_span && !missing;
        stage_next.meta.out_x       = pix.screen_x;
        stage_next.meta.out_y       = pix.screen_y;
        stage_next.w_m1             = w - DIM_W'(1);
        stage_next.h_m1             = h - DIM_W'(1);
        stage_next.off              = off_full[OFF_W-1:0];
        stage_next.len              = len_full[LEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            stage_reg <= stage_next;
            frac_reg  <= hit[FRAC_BITS-1:0];
        end
    end

endmodule

### rtl/core/wctc_mult.sv
// second stage: column scale and row numerator products
module wctc_mult
    import wctc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load_en,
    input  logic                 in_valid,
    input  prep_t                stage_in,
    input  logic [FRAC_BITS-1:0] frac,
    output logic                 valid_reg,
    output div_t                 stage_reg
);

    localparam int PROD_X_W = FRAC_BITS + DIM_W;

    logic [PROD_X_W-1:0] prod_x;
    logic [PROD_Y_W-1:0] prod_y;
    div_t                stage_next;

    // fraction times (width-1), offset times (height-1)
    always_comb begin
        prod_x = {{DIM_W{1'b0}}, frac} * {{FRAC_BITS{1'b0}}, stage_in.w_m1};
        prod_y = {{DIM_W{1'b0}}, stage_in.off} * {{OFF_W{1'b0}}, stage_in.h_m1};
    end

    // seed the divider: high part as remainder, low part shifted in
    always_comb begin
        stage_next.meta  = stage_in.meta;
        stage_next.tex_x = prod_x[PROD_X_W-1:FRAC_BITS];
        stage_next.rem   = {{(LEN_W-(PROD_Y_W-Q_W)){1'b0}}, prod_y[PROD_Y_W-1:Q_W]};
        stage_next.len   = stage_in.len;
        stage_next.qd    = prod_y[Q_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            stage_reg <= stage_next;
        end
    end

endmodule

### rtl/core/wctc_div_step.sv
// one restoring division step, one quotient bit per stage
module wctc_div_step
    import wctc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic load_en,
    input  logic in_valid,
    input  div_t stage_in,
    output logic valid_reg,
    output div_t stage_reg
);

    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             ge;
    div_t             stage_next;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        trial = {stage_in.rem, stage_in.qd[Q_W-1]};
        diff  = trial - {1'b0, stage_in.len};
        ge    = trial >= {1'b0, stage_in.len};
        stage_next       = stage_in;
        stage_next.rem   = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        stage_next.qd    = {stage_in.qd[Q_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            stage_reg <= stage_next;
        end
    end

endmodule

### rtl/core/wall_column_texel_coordinates_unit.sv
// top level of the wall column texel coordinate unit
// Takes one wall pixel per clock, unless a stalled consumer has filled the pipe, and
// returns its texture id, texel column and row, the draw flag and the red-fill flag
// for a missing texture. Throughput is one item per cycle while the pipe is not full.
// The pipe is one select stage, one multiply stage, a 13-stage pipelined restoring
// divider for the texel row and the output register. Any stage that holds no item
// takes a new one even while the output waits, so the pipe fills up behind a stalled
// consumer. Texture sizes are to be written on the cfg port only while the unit is
// idle; the unit does not enforce this. cfg_ready and s_tready stay low during reset,
// cfg_ready is high otherwise; indexes above 7 are ignored. No start-up clearing pass.
module wall_column_texel_coordinates_unit
    import wctc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768,
    parameter int FRAC_BITS     = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    // config write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  dim_t             cfg_data,
    // input items
    input  logic             s_tvalid,
    output logic             s_tready,
    // screen_x, screen_y, span_start, span_end, hit_x_coord, hit_y_coord
    input  logic [127:0]     s_tdata,
    // wall_side, step_x_positive, step_y_positive
    input  logic [2:0]       s_tuser,
    // result items
    output logic             m_tvalid,
    input  logic             m_tready,
    // texel_x, texel_y, out_x, out_y
    output logic [55:0]      m_tdata,
    // write_pixel, fill_red, texture_id[1:0]
    output logic [3:0]       m_tuser
);

    localparam int NUM_STG = DIV_STEPS + 3;

    dim_t                 tex_width  [NUM_TEX];
    dim_t                 tex_height [NUM_TEX];
    pix_t                 pix;
    logic [NUM_STG-1:0]   stg_valid;
    logic [NUM_STG:0]     stg_ready;
    prep_t                prep_q;
    logic [FRAC_BITS-1:0] frac_q;
    div_t                 div_q [DIV_STEPS+1];
    logic                 out_valid_reg;
    logic [TEXEL_W-1:0]   texel_x_reg;
    logic [TEXEL_W-1:0]   texel_y_reg;
    meta_t                out_meta_reg;

    assign cfg_ready = aresetn;

    wctc_cfg_regs u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (cfg_valid),
        .wr_index   (cfg_index),
        .wr_data    (cfg_data),
        .width_reg  (tex_width),
        .height_reg (tex_height)
    );

    // unpack the input item
    always_comb begin
        pix.screen_x        = s_tdata[15:0];
        pix.screen_y        = s_tdata[31:16];
        pix.span_start      = s_tdata[47:32];
        pix.span_end        = s_tdata[63:48];
        pix.hit_x_coord     = s_tdata[95:64];
        pix.hit_y_coord     = s_tdata[127:96];
        pix.wall_side       = s_tuser[0];
        pix.step_x_positive = s_tuser[1];
        pix.step_y_positive = s_tuser[2];
    end

    // a stage loads when it is empty or its successor loads
    always_comb begin
        stg_ready[NUM_STG] = m_tready;
        for (int i = NUM_STG - 1; i >= 0; i--) begin
            stg_ready[i] = !stg_valid[i] || stg_ready[i+1];
        end
    end

    assign s_tready = stg_ready[0] && aresetn;

    wctc_prep #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_en    (stg_ready[0]),
        .in_valid   (s_tvalid),
        .pix        (pix),
        .tex_width  (tex_width),
        .tex_height (tex_height),
        .valid_reg  (stg_valid[0]),
        .stage_reg  (prep_q),
        .frac_reg   (frac_q)
    );

    wctc_mult #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_en   (stg_ready[1]),
        .in_valid  (stg_valid[0]),
        .stage_in  (prep_q),
        .frac      (frac_q),
        .valid_reg (stg_valid[1]),
        .stage_reg (div_q[0])
    );

    // texel row divider chain
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        wctc_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load_en   (stg_ready[k+2]),
            .in_valid  (stg_valid[k+1]),
            .stage_in  (div_q[k]),
            .valid_reg (stg_valid[k+2]),
            .stage_reg (div_q[k+1])
        );
    end

    // output register with clamping, and zeroed texels for undrawn or red-filled pixels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (stg_ready[NUM_STG-1]) begin
            out_valid_reg <= stg_valid[NUM_STG-2];
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_ready[NUM_STG-1]) begin
            out_meta_reg <= div_q[DIV_STEPS].meta;
            if (div_q[DIV_STEPS].meta.active) begin
                texel_x_reg <= sat_texel(div_q[DIV_STEPS].tex_x);
                texel_y_reg <= sat_texel(div_q[DIV_STEPS].qd);
            end else begin
                texel_x_reg <= '0;
                texel_y_reg <= '0;
            end
        end
    end

    assign stg_valid[NUM_STG-1] = out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_meta_reg.out_y, out_meta_reg.out_x, texel_y_reg, texel_x_reg};
    assign m_tuser  = {out_meta_reg.texture_id, out_meta_reg.fill_red,
                       out_meta_reg.write_pixel};

endmodule

### tb/wctc_checker.sv
// checker for the wall column texel coordinate unit: predicts each pixel and compares results
`timescale 1ns / 1ps

module wctc_checker
    import wctc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768,
    parameter int FRAC_BITS     = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  dim_t             cfg_data,
    input  logic             s_tvalid,
    input  logic             s_tready,
    // screen_x, screen_y, span_start, span_end, hit_x_coord, hit_y_coord
    input  logic [127:0]     s_tdata,
    // wall_side, step_x_positive, step_y_positive
    input  logic [2:0]       s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    // texel_x, texel_y, out_x, out_y
    input  logic [55:0]      m_tdata,
    // write_pixel, fill_red, texture_id[1:0]
    input  logic [3:0]       m_tuser,
    output int               mismatches,
    output int               pending
);

    typedef struct packed {
        logic                 write_pixel;
        logic                 fill_red;
        logic [1:0]           texture_id;
        logic [TEXEL_W-1:0]   texel_x;
        logic [TEXEL_W-1:0]   texel_y;
        logic [COORD_W-1:0]   out_x;
        logic [COORD_W-1:0]   out_y;
    } texel_result_t;

    // texture sizes as last written, indexed by texture id
    dim_t tex_w [NUM_TEX];
    dim_t tex_h [NUM_TEX];

    texel_result_t texel_results_due[$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic logic [TEXEL_W-1:0] clamp_texel(input longint unsigned v);
        return (v > longint'(TEXEL_MAX)) ? TEXEL_MAX : v[TEXEL_W-1:0];
    endfunction

    // texture choice, span checks and texel addressing for one pixel
    function automatic texel_result_t predict_texel(input logic [127:0] d, input logic [2:0] u);
        int               px, py, first, last;
        logic [HIT_W-1:0] hit;
        logic [1:0]       id;
        dim_t             w, h;
        bit               missing, on_screen, in_span;
        longint unsigned  frac, off, len;
        texel_result_t    r;
        px    = $signed(d[15:0]);
        py    = $signed(d[31:16]);
        first = $signed(d[47:32]);
        last  = $signed(d[63:48]);
        if (u[0]) begin
            hit = d[127:96];
            id  = u[2] ? TEX_SOUTH : TEX_NORTH;
        end else begin
            hit = d[95:64];
            id  = u[1] ? TEX_EAST : TEX_WEST;
        end
        w = tex_w[id];
        h = tex_h[id];
        missing = (w == 0) || (h == 0);
        // short span is stretched to two rows, but only for a present texture
        if (!missing && last <= first)
            last = first + 1;
        on_screen = px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT;
        in_span   = py >= first && py <= last;
        r = '0;
        r.write_pixel = on_screen && in_span;
        r.fill_red    = missing;
        r.texture_id  = id;
        r.out_x       = d[15:0];
        r.out_y       = d[31:16];
        if (r.write_pixel && !missing) begin
            frac = hit & ((64'd1 << FRAC_BITS) - 1);
            off  = longint'(py - first);
            len  = longint'(last - first + 1);
            r.texel_x = clamp_texel((frac * (longint'(w) - 1)) >> FRAC_BITS);
            r.texel_y = clamp_texel((off * (longint'(h) - 1)) / len);
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        texel_result_t want, got;
        if (!aresetn) begin
            texel_results_due.delete();
            for (int i = 0; i < NUM_TEX; i++) begin
                tex_w[i] = '0;
                tex_h[i] = '0;
            end
        end else begin
            // result side first so a fresh pixel never meets its own slot
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tuser[1], m_tuser[3:2], m_tdata[11:0], m_tdata[23:12],
                       m_tdata[39:24], m_tdata[55:40]};
                if (texel_results_due.size() == 0) begin
                    $display("%0t ns: result item with none expected, actual %h", $time, got);
                    mismatches++;
                end else begin
                    want = texel_results_due.pop_front();
                    compare_field("write_pixel", want.write_pixel, got.write_pixel);
                    compare_field("fill_red", want.fill_red, got.fill_red);
                    compare_field("texture_id", want.texture_id, got.texture_id);
                    compare_field("texel_x", want.texel_x, got.texel_x);
                    compare_field("texel_y", want.texel_y, got.texel_y);
                    compare_field("out_x", want.out_x, got.out_x);
                    compare_field("out_y", want.out_y, got.out_y);
                end
            end
            if (s_tvalid && s_tready)
                texel_results_due.push_back(predict_texel(s_tdata, s_tuser));
            // register write lands after any pixel taken on the same edge
            if (cfg_valid && cfg_ready && cfg_index <= CFG_EAST_HEIGHT) begin
                if (cfg_index[0])
                    tex_h[cfg_index[2:1]] = cfg_data;
                else
                    tex_w[cfg_index[2:1]] = cfg_data;
            end
        end
        pending = texel_results_due.size();
    end

endmodule

### tb/tb_top.sv
// testbench top for the wall column texel coordinate unit: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_top
    import wctc_pkg::*;
();

    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_WAIT    = 24;
    localparam int SCREEN_W_LAST = 1023;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    dim_t             cfg_data  = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [127:0]     s_tdata   = '0;
    logic [2:0]       s_tuser   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [55:0]      m_tdata;
    logic [3:0]       m_tuser;

    int mismatches;
    int pending;
    int stall_cycles = 0;
    bit idling = 1'b1;

    wall_column_texel_coordinates_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    wctc_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result side backpressure
    always @(negedge aclk) begin
        m_tready <= idling ? ($urandom_range(99) >= 23) : 1'b1;
    end

    // watchdog on cycles with no item moving anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("wall_column_texel_coordinates_unit: mismatch");
            $finish;
        end
    end

    // one pixel item, with random gaps ahead of it while idling is set
    task automatic drive_pixel(input int x, input int y, input int first, input int last,
                               input bit side, input logic [31:0] hx, input logic [31:0] hy,
                               input bit sx, input bit sy);
        while (idling && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hy, hx, 16'(last), 16'(first), 16'(y), 16'(x)};
        s_tuser  <= {sy, sx, side};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input dim_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic load_textures(input dim_t nw, input dim_t nh, input dim_t sw, input dim_t sh,
                                 input dim_t ww, input dim_t wh, input dim_t ew, input dim_t eh);
        write_reg(CFG_NORTH_WIDTH, nw);
        write_reg(CFG_NORTH_HEIGHT, nh);
        write_reg(CFG_SOUTH_WIDTH, sw);
        write_reg(CFG_SOUTH_HEIGHT, sh);
        write_reg(CFG_WEST_WIDTH, ww);
        write_reg(CFG_WEST_HEIGHT, wh);
        write_reg(CFG_EAST_WIDTH, ew);
        write_reg(CFG_EAST_HEIGHT, eh);
        // a write past the last register must change nothing
        write_reg(IDX_W'(CFG_EAST_HEIGHT + $urandom_range(1, 8)), dim_t'($urandom));
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // stop sending and let the pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    function automatic dim_t pick_dim();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)  return '0;
        if (r < 16) return dim_t'(1);
        if (r < 24) return dim_t'(4096);
        if (r < 30) return dim_t'($urandom_range(4097, 8191));
        if (r < 70) return dim_t'($urandom_range(2, 256));
        return dim_t'($urandom_range(2, 4095));
    endfunction

    // mostly well-formed wall pixels, some raw noise
    task automatic random_pixel();
        int first, last, x, y;
        first = $urandom_range(0, 1100) - 200;
        if ($urandom_range(9) == 0)
            last = first - $urandom_range(0, 5);
        else
            last = first + $urandom_range(0, 1000);
        x = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, SCREEN_W_LAST);
        y = ($urandom_range(1) == 0) ? first + $urandom_range(0, 2 + last - first)
                                     : $urandom_range(0, 767);
        if ($urandom_range(99) < 20) begin
            x     = $urandom;
            y     = $urandom;
            first = $urandom;
            last  = $urandom;
        end
        drive_pixel(x, y, first, last, $urandom_range(1), $urandom, $urandom,
                    $urandom_range(1), $urandom_range(1));
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // all textures missing after reset
        drive_pixel(10, 10, 5, 20, 1, 0, 32'h0001_8000, 0, 0);
        drive_pixel(10, 10, 20, 5, 0, 32'h1234_5678, 0, 1, 0);
        drive_pixel(10, 5, 5, 5, 0, 32'hFFFF_FFFF, 0, 0, 1);
        drive_pixel(10, 6, 5, 5, 1, 0, 32'hFFFF_0000, 1, 1);
        drive_pixel(-1, 10, 5, 20, 1, 0, 32'h0000_FFFF, 0, 0);
        settle();

        // texture sizes of 1 and 4096, then screen and span edge pixels
        load_textures(64, 64, 4096, 4096, 1, 1, 200, 37);
        drive_pixel(100, 50, 0, 99, 1, 0, 32'h0000_8000, 0, 0);
        drive_pixel(0, 0, 0, 767, 1, 0, 32'hFFFF_FFFF, 0, 1);
        drive_pixel(1023, 767, 700, 767, 0, 32'h8000_0000, 0, 0, 0);
        drive_pixel(512, 400, -100, 900, 0, 32'h7FFF_FFFF, 0, 1, 0);
        drive_pixel(-1, 10, 0, 20, 0, 32'h0000_4000, 0, 1, 0);
        drive_pixel(1024, 10, 0, 20, 1, 0, 32'h0000_4000, 0, 1);
        drive_pixel(10, 768, 700, 800, 1, 0, 32'h0000_4000, 0, 0);
        drive_pixel(10, -1, -5, 5, 0, 32'h0000_4000, 0, 1, 0);
        drive_pixel(-32768, 32767, -32768, 32767, 1, 0, 32'h0000_4000, 0, 1);
        drive_pixel(5, 9, 10, 20, 1, 0, 32'h0000_4000, 0, 0);
        drive_pixel(5, 21, 10, 20, 1, 0, 32'h0000_4000, 0, 0);
        // short spans stretch to start+1
        drive_pixel(5, 11, 10, 10, 1, 0, 32'h0000_C000, 0, 0);
        drive_pixel(5, 11, 10, 3, 0, 32'h0000_C000, 0, 1, 0);
        drive_pixel(5, 10, 10, 10, 1, 0, 32'h0000_C000, 0, 1);
        drive_pixel(5, 767, 32767, -32768, 1, 0, 32'h0000_C000, 0, 1);
        // negative hit keeps its fraction above the floor
        drive_pixel(300, 300, 0, 600, 0, 32'hFFFE_8000, 0, 1, 0);
        drive_pixel(300, 767, -32768, 32767, 0, 32'h0000_0001, 0, 1, 0);
        drive_pixel(300, 1, 0, 1, 1, 0, 32'h0000_0000, 0, 1);

        // random phases, each with its own texture sizes
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            if (ph == 0)
                load_textures(0, 64, 64, 0, 8191, 8191, 4096, 1);
            else
                load_textures(pick_dim(), pick_dim(), pick_dim(), pick_dim(),
                              pick_dim(), pick_dim(), pick_dim(), pick_dim());
            idling <= (ph != 2);
            repeat (285) random_pixel();
        end

        settle();
        if (mismatches == 0)
            $display("wall_column_texel_coordinates_unit: match");
        else
            $display("wall_column_texel_coordinates_unit: mismatch");
        $finish;
    end

endmodule
